[rtl/core/lirs_pkg.sv]
`default_nettype none

package lirs_pkg;

   localparam int SampleWidth = 16;
   localparam int StepWidth = 20;
   localparam int PhaseWidth = 21;
   localparam int FracWidth = 16;
   localparam int MaxOutputs = 64;
   localparam int CountWidth = $clog2(MaxOutputs);
   localparam int QueueDepth = 4;

   localparam logic [StepWidth-1:0] StepReset = StepWidth'(65536);
   localparam logic [PhaseWidth-1:0] PhaseOne = PhaseWidth'(65536);

   typedef logic signed [SampleWidth-1:0] sample_type;
   typedef logic [StepWidth-1:0] step_type;
   typedef logic [PhaseWidth-1:0] phase_type;

   // One queued input word, tagged by the front with whether it opens a buffer.
   typedef struct packed {
      sample_type sample;
      logic       buffer_end;
      logic       first;
   } item_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_RUN
   } back_state_type;

endpackage

`default_nettype wire

[rtl/core/lirs_req_if.sv]
`default_nettype none

interface lirs_req_if;
   logic                 valid;
   logic                 ready;
   lirs_pkg::sample_type sample_in;
   logic                 buffer_end;

   modport source (output valid, output sample_in, output buffer_end, input ready);
   modport sink (input valid, input sample_in, input buffer_end, output ready);
endinterface

`default_nettype wire

[rtl/core/lirs_rsp_if.sv]
`default_nettype none

interface lirs_rsp_if;
   logic                 valid;
   logic                 ready;
   lirs_pkg::sample_type sample_out;
   logic                 run_last;

   modport source (output valid, output sample_out, output run_last, input ready);
   modport sink (input valid, input sample_out, input run_last, output ready);
endinterface

`default_nettype wire

[rtl/core/lirs_front.sv]
`default_nettype none

module lirs_front #(
   parameter int QueueDepth = lirs_pkg::QueueDepth
) (
   input  wire logic         clock,
   input  wire logic         reset,
   lirs_req_if.sink          req,
   output lirs_pkg::item_type item,
   output logic              item_valid,
   input  wire logic         item_pop
);
   import lirs_pkg::*;

   localparam int PtrWidth = $clog2(QueueDepth);
   localparam int FillWidth = $clog2(QueueDepth + 1);

   item_type               queue_ff [QueueDepth];
   logic [PtrWidth-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [FillWidth-1:0]   fill_ff, fill_in;
   logic                   have_prev_ff, have_prev_in;
   logic                   push;
   logic                   pop;
   item_type               new_item;

   assign req.ready = (fill_ff != FillWidth'(QueueDepth));
   assign push = req.valid && req.ready;
   assign item_valid = (fill_ff != '0);
   assign pop = item_pop && item_valid;
   assign item = queue_ff[rd_ptr_ff];

   // The first word after reset or after a buffer end opens a new buffer.
   always_comb begin
      new_item.sample = req.sample_in;
      new_item.buffer_end = req.buffer_end;
      new_item.first = !have_prev_ff;
   end

   always_comb begin
      have_prev_in = have_prev_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         have_prev_in = !req.buffer_end;
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      fill_in = fill_ff + FillWidth'(push) - FillWidth'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff <= 1'b0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         have_prev_ff <= have_prev_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

`default_nettype wire

[rtl/core/lirs_back.sv]
`default_nettype none

module lirs_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire lirs_pkg::item_type item,
   input  wire logic              item_valid,
   output logic                   item_pop,
   input  wire lirs_pkg::step_type step_ratio,
   lirs_rsp_if.source             rsp
);
   import lirs_pkg::*;

   back_state_type          state_ff, state_in;
   sample_type              prev_ff;
   sample_type              cur_ff;
   logic                    end_ff;
   phase_type               phase_ff;
   logic [CountWidth-1:0]   count_ff;
   logic                    rsp_valid_ff;
   sample_type              rsp_sample_ff;
   logic                    rsp_last_ff;

   logic                    out_free;
   logic                    emit;
   logic                    phase_below_one;
   logic signed [SampleWidth:0]     diff;
   logic signed [2*SampleWidth+1:0] product;
   sample_type              interp;
   phase_type               phase_sum;
   logic                    sum_past_one;
   logic                    run_done;
   phase_type               phase_after;

   assign rsp.valid = rsp_valid_ff;
   assign rsp.sample_out = rsp_sample_ff;
   assign rsp.run_last = rsp_last_ff;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign phase_below_one = (phase_ff[PhaseWidth-1:FracWidth] == '0);

   // The product's bits above the fraction are the floor of the scaled difference.
   always_comb begin
      diff = {cur_ff[SampleWidth-1], cur_ff} - {prev_ff[SampleWidth-1], prev_ff};
      product = diff * $signed({1'b0, phase_ff[FracWidth-1:0]});
      interp = prev_ff + product[FracWidth+SampleWidth-1:FracWidth];
      phase_sum = phase_ff + PhaseWidth'(step_ratio);
      sum_past_one = (phase_sum[PhaseWidth-1:FracWidth] != '0);
      run_done = sum_past_one || (count_ff == CountWidth'(MaxOutputs - 1));
      phase_after = sum_past_one ? phase_sum - PhaseOne : '0;
   end

   always_comb begin
      item_pop = 1'b0;
      emit = 1'b0;
      unique case (state_ff)
         BACK_IDLE: begin
            item_pop = item_valid;
         end
         BACK_RUN: begin
            emit = out_free;
         end
         default: begin
            item_pop = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_IDLE: begin
            if (item_valid && !item.first && phase_below_one) begin
               state_in = BACK_RUN;
            end
         end
         BACK_RUN: begin
            if (emit && run_done) begin
               state_in = BACK_IDLE;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_IDLE;
         prev_ff <= '0;
         phase_ff <= '0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (item_pop) begin
            if (!item.first && phase_below_one) begin
               count_ff <= '0;
            end else begin
               // A word that emits nothing closes its interval at once.
               prev_ff <= item.buffer_end ? '0 : item.sample;
               if (item.buffer_end || item.first) begin
                  phase_ff <= '0;
               end else begin
                  phase_ff <= phase_ff - PhaseOne;
               end
            end
         end
         if (emit) begin
            count_ff <= count_ff + 1'b1;
            if (run_done) begin
               phase_ff <= end_ff ? '0 : phase_after;
               prev_ff <= end_ff ? '0 : cur_ff;
            end else begin
               phase_ff <= phase_sum;
            end
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_pop) begin
         cur_ff <= item.sample;
         end_ff <= item.buffer_end;
      end
      if (emit) begin
         rsp_sample_ff <= interp;
         rsp_last_ff <= run_done;
      end
   end

endmodule

`default_nettype wire

[rtl/core/linear_interp_resampler_unit.sv]
// Streaming linear-interpolation resampler for pitch shifting.
// Input words arrive on req (valid/ready) with a signed 16-bit sample and a
// buffer_end flag; interpolated words leave on rsp with run_last set on the
// last word produced by each input word. The step ratio is an unsigned Q4.16
// value written through csr_write_enable and csr_write_data while the block
// is idle, which the user must ensure since the block does not enforce it;
// it resets to 1.0. Input words enter a small queue, so req stays ready until
// four words wait. The back end takes one queued word per cycle when idle; a
// word that produces nothing (the first of a buffer, or one skipped by a large
// step) is consumed at once. Otherwise the word is loaded and then yields its
// output words, at most 64; the 17 by 17 interpolation multiplier produces one
// output per cycle while rsp is not stalled. An input word reaches rsp through
// the queue, the back end's sample register and the output register.
// When rsp stalls, the output register holds its word and the back end waits;
// the queue keeps taking input until it is full.
// Reset empties the queue, clears the previous sample and read phase, and
// sets the step ratio to 1.0.
`default_nettype none

module linear_interp_resampler_unit #(
   parameter int QueueDepth = lirs_pkg::QueueDepth
) (
   input  wire logic                clock,
   input  wire logic                reset,
   lirs_req_if.sink                 req,
   lirs_rsp_if.source               rsp,
   input  wire logic                csr_write_enable,
   input  wire lirs_pkg::step_type  csr_write_data
);
   import lirs_pkg::*;

   step_type step_ratio_ff;
   item_type item;
   logic     item_valid;
   logic     item_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ratio_ff <= StepReset;
      end else if (csr_write_enable) begin
         step_ratio_ff <= csr_write_data;
      end
   end

   lirs_front #(
      .QueueDepth(QueueDepth)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .item       (item),
      .item_valid (item_valid),
      .item_pop   (item_pop)
   );

   lirs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item       (item),
      .item_valid (item_valid),
      .item_pop   (item_pop),
      .step_ratio (step_ratio_ff),
      .rsp        (rsp)
   );

endmodule

`default_nettype wire

[test/linear_interp_resampler_unit_test.sv]
`timescale 1ns / 100ps

module linear_interp_resampler_unit_test;
   import lirs_pkg::*;

   typedef struct packed {
      sample_type sample;
      logic       run_last;
   } out_word_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   step_type csr_write_data;

   lirs_req_if req_bus ();
   lirs_rsp_if rsp_bus ();

   linear_interp_resampler_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_bus),
      .rsp              (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Model state of the resampler, advanced once per accepted input word.
   step_type   model_step = StepReset;
   sample_type model_prev = '0;
   logic       model_prev_valid = 1'b0;
   phase_type  model_phase = '0;

   out_word_type expected_words[$];

   logic no_gaps = 1'b0;
   int   error_count = 0;
   int   words_sent = 0;
   int   words_checked = 0;
   int   step_writes = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("Timed out with %0d output words still expected.", expected_words.size());
      $display("[linear_interp_resampler_unit] ERROR");
      $finish;
   end

   task automatic predict_outputs(input sample_type cur, input logic last);
      longint       diff;
      longint       product;
      int           produced;
      out_word_type word;
      produced = 0;
      if (!model_prev_valid) begin
         model_prev = cur;
         model_prev_valid = 1'b1;
         model_phase = '0;
      end else begin
         diff = longint'(cur) - longint'(model_prev);
         while (model_phase < PhaseOne && produced < MaxOutputs) begin
            product = diff * longint'(model_phase);
            word.sample = sample_type'(longint'(model_prev) + (product >>> FracWidth));
            word.run_last = 1'b0;
            expected_words.insert(expected_words.size(), word);
            produced++;
            model_phase = model_phase + phase_type'(model_step);
         end
         if (model_phase >= PhaseOne) begin
            model_phase = model_phase - PhaseOne;
         end else begin
            model_phase = '0;
         end
         if (produced > 0) begin
            expected_words[expected_words.size() - 1].run_last = 1'b1;
         end
         model_prev = cur;
      end
      if (last) begin
         model_prev = '0;
         model_prev_valid = 1'b0;
         model_phase = '0;
      end
   endtask

   task automatic send_word(input sample_type sample, input logic last);
      while (!no_gaps && $urandom_range(99) < 14) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.sample_in <= sample;
      req_bus.buffer_end <= last;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      predict_outputs(sample, last);
      words_sent++;
   endtask

   // A word that yields nothing may still sit in the input queue after the
   // last expected output, so a margin of cycles follows the drain.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (expected_words.size() != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);
   endtask

   task automatic set_step(input step_type value);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      model_step = value;
      step_writes++;
   endtask

   initial begin
      out_word_type want;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) begin
            words_checked++;
            if (expected_words.size() == 0) begin
               $display("%0t: output word %0d with run_last %0b arrived with none expected",
                        $time, rsp_bus.sample_out, rsp_bus.run_last);
               error_count++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_bus.sample_out !== want.sample) begin
                  $display("%0t: sample_out expected %0d got %0d",
                           $time, want.sample, rsp_bus.sample_out);
                  error_count++;
               end
               if (rsp_bus.run_last !== want.run_last) begin
                  $display("%0t: run_last expected %0b got %0b",
                           $time, want.run_last, rsp_bus.run_last);
                  error_count++;
               end
            end
         end
         rsp_bus.ready <= !reset && (no_gaps || $urandom_range(99) >= 14);
      end
   end

   task automatic test_unit_step_extremes();
      send_word(16'sh7fff, 1'b0);
      send_word(16'sh8000, 1'b0);
      send_word(-16'sd1, 1'b0);
      send_word(16'sd0, 1'b0);
      send_word(16'sd1, 1'b1);
   endtask

   task automatic test_short_buffers();
      send_word(16'sh8000, 1'b1);
      send_word(16'sh7fff, 1'b1);
   endtask

   task automatic test_step_extremes();
      set_step(StepWidth'(1024));
      send_word(16'sh8000, 1'b0);
      send_word(16'sh7fff, 1'b0);
      send_word(16'sh8000, 1'b1);

      // The largest step leaves the phase above one, so later intervals are skipped.
      set_step('1);
      send_word(16'sd100, 1'b0);
      send_word(-16'sd100, 1'b0);
      send_word(16'sd5000, 1'b0);
      send_word(16'sd7, 1'b0);
      send_word(-16'sd7, 1'b0);
      send_word(16'sd1, 1'b1);

      // Steps below the minimum hit the cap of output words per interval.
      set_step('0);
      send_word(16'sd10, 1'b0);
      send_word(-16'sd20, 1'b0);
      send_word(16'sd30, 1'b1);
      set_step(StepWidth'(1023));
      send_word(16'sh7fff, 1'b0);
      send_word(16'sh8000, 1'b1);
   endtask

   task automatic test_random_buffers(input int phase_total, input int items_per_phase);
      int         left;
      int         len;
      sample_type sample;
      for (int p = 0; p < phase_total; p++) begin
         case (p % 5)
            0: set_step(step_type'($urandom_range(32768, 131072)));
            1: set_step(step_type'($urandom_range(1024, 1048575)));
            2: set_step(StepWidth'(1024));
            3: set_step(step_type'($urandom_range(131072, 1048575)));
            default: set_step(StepReset);
         endcase
         no_gaps = (p % 5 == 2);
         left = items_per_phase;
         while (left > 0) begin
            len = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 12);
            if (len > left) begin
               len = left;
            end
            for (int k = 0; k < len; k++) begin
               case ($urandom_range(7))
                  0: sample = 16'sh7fff;
                  1: sample = 16'sh8000;
                  default: sample = sample_type'($urandom);
               endcase
               send_word(sample, k == len - 1);
            end
            left -= len;
         end
         no_gaps = 1'b0;
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.sample_in <= '0;
      req_bus.buffer_end <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_write_data <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_unit_step_extremes();
      test_short_buffers();
      test_step_extremes();
      test_random_buffers(5, 17);
      wait_drained();

      $display("Sent %0d input words and checked %0d output words over %0d step writes,",
               words_sent, words_checked, step_writes);
      $display("covering unit, minimum, maximum, zero and below-minimum steps and random buffers.");
      if (error_count == 0) begin
         $display("[linear_interp_resampler_unit] OK");
      end else begin
         $display("[linear_interp_resampler_unit] ERROR");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/core/lirs_pkg.sv
rtl/core/lirs_req_if.sv
rtl/core/lirs_rsp_if.sv
rtl/core/lirs_front.sv
rtl/core/lirs_back.sv
rtl/core/linear_interp_resampler_unit.sv
test/linear_interp_resampler_unit_test.sv
